// ===== rtl/lifo_pkg.sv =====
// Package for the bounded LIFO stack: sizes, op and status codes, state type.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package lifo_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;
   localparam int CAP_W  = 7;

   // request op codes; code 3 means nothing and is dropped
   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_DUMP = 2'd2
   } op_type;

   // response status codes
   typedef enum logic [2:0] {
      STAT_PUSHED = 3'd0,
      STAT_FULL   = 3'd1,
      STAT_POPPED = 3'd2,
      STAT_EMPTY  = 3'd3,
      STAT_DUMP   = 3'd4
   } status_type;

   // control sequencer states
   typedef enum logic {
      SEQ_IDLE = 1'b0,
      SEQ_DUMP = 1'b1
   } seq_type;

endpackage

`default_nettype wire

// ===== rtl/lifo_if.sv =====
// Valid/ready channel interfaces for the request, response and CSR words.
// Depends on lifo_pkg for field widths.
`default_nettype none

interface lifo_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [1:0]                               op;
   logic signed [lifo_pkg::WORD_W-1:0]       value;
   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface lifo_rsp_if;
   logic                                     valid;
   logic                                     ready;
   logic [2:0]                               status;
   logic signed [lifo_pkg::WORD_W-1:0]       data;
   logic                                     last;
   modport source (output valid, output status, output data, output last, input ready);
   modport sink   (input valid, input status, input data, input last, output ready);
endinterface

interface lifo_csr_if;
   logic                                     valid;
   logic                                     ready;
   logic [lifo_pkg::CAP_W-1:0]               data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bounded_lifo_stack.sv =====
// Top level of the bounded LIFO stack: storage memory, fill level, dump walker.
// Depends on lifo_pkg and the channel interfaces in lifo_if.sv.
//
//   channel   direction  word contents
//   req_ch    in         op, value
//   rsp_ch    out        status, data, last
//   csr_ch    in         capacity
//
// Push, full and empty: the response word goes straight into the output
// register. Pop: the top entry is read into the read-data register, then moved
// to the output register. Dump: entries are read top to bottom, one word per cycle while the response side takes them;
// the request side stays stalled until the last dump word has left the
// read-data register.
// Reset clears fill level, capacity (to DEPTH) and all handshake state; the
// memory is not cleared. A stalled response holds the output register, one
// read-data register behind it, and the memory reads.
`default_nettype none

module bounded_lifo_stack (
   input  wire              clock,
   input  wire              reset,
   lifo_req_if.sink         req_ch,
   lifo_rsp_if.source       rsp_ch,
   lifo_csr_if.sink         csr_ch
);

   localparam int AW = lifo_pkg::ADDR_W;
   localparam int FW = lifo_pkg::FILL_W;
   localparam int WW = lifo_pkg::WORD_W;
   localparam int CW = lifo_pkg::CAP_W;

   // storage memory and its registered read word
   logic [WW-1:0] mem [lifo_pkg::DEPTH];
   logic [WW-1:0] mem_q_ff;

   lifo_pkg::seq_type    state_ff, state_in;
   logic [FW-1:0]        fill_ff, fill_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        cap_ff, cap_in;
   logic                 pend_ff, pend_in;
   lifo_pkg::status_type pend_status_ff, pend_status_in;
   logic                 pend_last_ff, pend_last_in;
   logic                 out_valid_ff, out_valid_in;
   lifo_pkg::status_type out_status_ff, out_status_in;
   logic [WW-1:0]        out_data_ff, out_data_in;
   logic                 out_last_ff, out_last_in;

   logic                 out_free;
   logic                 pend_to_out;
   logic                 req_take;
   logic                 full;
   logic [FW-1:0]        limit;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic                 mem_re;
   logic [AW-1:0]        mem_raddr;

   // saturate capacity into 1..DEPTH
   always_comb begin
      if (cap_ff == '0) begin
         limit = FW'(1);
      end else if (FW'(cap_ff) > FW'(lifo_pkg::DEPTH)) begin
         limit = FW'(lifo_pkg::DEPTH);
      end else begin
         limit = FW'(cap_ff);
      end
   end

   assign full        = (fill_ff >= limit);
   assign out_free    = !out_valid_ff || rsp_ch.ready;
   assign pend_to_out = pend_ff && out_free;
   assign req_ch.ready = (state_ff == lifo_pkg::SEQ_IDLE) && !pend_ff && out_free;
   assign req_take    = req_ch.valid && req_ch.ready;

   assign csr_ch.ready = 1'b1;

   // sequencer: next state, memory controls, pending and output stages
   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      idx_in         = idx_ff;
      pend_in        = pend_ff;
      pend_status_in = pend_status_ff;
      pend_last_in   = pend_last_ff;
      out_valid_in   = out_valid_ff;
      out_status_in  = out_status_ff;
      out_data_in    = out_data_ff;
      out_last_in    = out_last_ff;
      mem_we         = 1'b0;
      mem_waddr      = fill_ff[AW-1:0];
      mem_re         = 1'b0;
      mem_raddr      = idx_ff;

      // drop the output word once taken
      if (out_valid_ff && rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end

      // advance the read word into the output register
      if (pend_to_out) begin
         out_valid_in  = 1'b1;
         out_status_in = pend_status_ff;
         out_data_in   = mem_q_ff;
         out_last_in   = pend_last_ff;
         pend_in       = 1'b0;
      end

      case (state_ff)
         lifo_pkg::SEQ_IDLE: begin
            if (req_take) begin
               case (req_ch.op)
                  lifo_pkg::OP_PUSH: begin
                     out_valid_in = 1'b1;
                     out_data_in  = '0;
                     out_last_in  = 1'b1;
                     if (full) begin
                        out_status_in = lifo_pkg::STAT_FULL;
                     end else begin
                        out_status_in = lifo_pkg::STAT_PUSHED;
                        mem_we        = 1'b1;
                        fill_in       = fill_ff + FW'(1);
                     end
                  end
                  lifo_pkg::OP_POP: begin
                     if (fill_ff == '0) begin
                        out_valid_in  = 1'b1;
                        out_status_in = lifo_pkg::STAT_EMPTY;
                        out_data_in   = '0;
                        out_last_in   = 1'b1;
                     end else begin
                        mem_re         = 1'b1;
                        mem_raddr      = AW'(fill_ff - FW'(1));
                        fill_in        = fill_ff - FW'(1);
                        pend_in        = 1'b1;
                        pend_status_in = lifo_pkg::STAT_POPPED;
                        pend_last_in   = 1'b1;
                     end
                  end
                  lifo_pkg::OP_DUMP: begin
                     if (fill_ff == '0) begin
                        out_valid_in  = 1'b1;
                        out_status_in = lifo_pkg::STAT_EMPTY;
                        out_data_in   = '0;
                        out_last_in   = 1'b1;
                     end else begin
                        idx_in   = AW'(fill_ff - FW'(1));
                        state_in = lifo_pkg::SEQ_DUMP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         lifo_pkg::SEQ_DUMP: begin
            // read the next entry when the read-data register frees up
            if (!pend_ff || pend_to_out) begin
               mem_re         = 1'b1;
               mem_raddr      = idx_ff;
               pend_in        = 1'b1;
               pend_status_in = lifo_pkg::STAT_DUMP;
               pend_last_in   = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = lifo_pkg::SEQ_IDLE;
               end else begin
                  idx_in = idx_ff - AW'(1);
               end
            end
         end
         default: begin
            state_in = lifo_pkg::SEQ_IDLE;
         end
      endcase
   end

   // capacity register
   always_comb begin
      cap_in = cap_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         cap_in = csr_ch.data;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lifo_pkg::SEQ_IDLE;
         fill_ff      <= '0;
         cap_ff       <= CW'(lifo_pkg::DEPTH);
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cap_ff       <= cap_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      pend_status_ff <= pend_status_in;
      pend_last_ff   <= pend_last_in;
      out_status_ff  <= out_status_in;
      out_data_ff    <= out_data_in;
      out_last_ff    <= out_last_in;
   end

   // storage memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= req_ch.value;
      end
      if (mem_re) begin
         mem_q_ff <= mem[mem_raddr];
      end
   end

   assign rsp_ch.valid  = out_valid_ff;
   assign rsp_ch.status = out_status_ff;
   assign rsp_ch.data   = out_data_ff;
   assign rsp_ch.last   = out_last_ff;

   // fill level never passes the memory depth
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(lifo_pkg::DEPTH))
      else $error("fill level above depth");

   // a new request never starts while a read word is still waiting
   a_take_no_pend: assert property (@(posedge clock) disable iff (reset)
      req_take |-> !pend_ff)
      else $error("request taken with pending read word");

   // a waiting read word holds until it moves to the output
   a_pend_hold: assert property (@(posedge clock) disable iff (reset)
      pend_ff && !out_free |=> pend_ff && $stable(mem_q_ff))
      else $error("pending read word lost");

   // the dump walker stays below the fill level
   a_dump_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == lifo_pkg::SEQ_DUMP |-> FW'(idx_ff) < fill_ff)
      else $error("dump index out of range");

endmodule

`default_nettype wire

// ===== verif/bounded_lifo_stack_tb.sv =====
// Self-checking testbench for bounded_lifo_stack: push, pop and dump traffic
// against a stack predictor, with random stalls and capacity changes.
// Depends on lifo_pkg and the channel interfaces in lifo_if.sv.
`default_nettype none

module bounded_lifo_stack_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // op code 3 has no meaning in the block; it must be dropped silently
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 20;
   localparam int LONG_HOLD     = 300;
   localparam int RANDOM_ITEMS  = 330;
   localparam int PHASE_ITEMS   = 45;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      lifo_pkg::status_type               status;
      logic signed [lifo_pkg::WORD_W-1:0] data;
      logic                               last;
   } rsp_word_type;

   // Stack predictor plus the queue of response words still owed
   class stack_scoreboard;
      logic signed [lifo_pkg::WORD_W-1:0] stack_words [lifo_pkg::DEPTH];
      int unsigned  fill_level;
      int unsigned  capacity;
      rsp_word_type owed_q[$];
      int unsigned  mismatches;
      int unsigned  words_checked;
      int unsigned  pushes, pops, dumps, fulls, empties, deepest;

      function new();
         fill_level = 0;
         capacity   = lifo_pkg::DEPTH;
      endfunction

      function void set_capacity(int unsigned value);
         capacity = value;
      endfunction

      // saturate the register into 1..DEPTH
      function int unsigned push_limit();
         if (capacity < 1) return 1;
         if (capacity > lifo_pkg::DEPTH) return lifo_pkg::DEPTH;
         return capacity;
      endfunction

      function void owe(lifo_pkg::status_type status,
                        logic signed [lifo_pkg::WORD_W-1:0] data, logic last);
         rsp_word_type w;
         w.status = status;
         w.data   = data;
         w.last   = last;
         owed_q.push_back(w);
      endfunction

      function void note_request(logic [1:0] op, logic signed [lifo_pkg::WORD_W-1:0] value);
         int unsigned i;
         case (op)
            lifo_pkg::OP_PUSH: begin
               pushes++;
               if (fill_level >= push_limit()) begin
                  fulls++;
                  owe(lifo_pkg::STAT_FULL, '0, 1'b1);
               end else begin
                  stack_words[fill_level] = value;
                  fill_level++;
                  if (fill_level > deepest) deepest = fill_level;
                  owe(lifo_pkg::STAT_PUSHED, '0, 1'b1);
               end
            end
            lifo_pkg::OP_POP: begin
               pops++;
               if (fill_level == 0) begin
                  empties++;
                  owe(lifo_pkg::STAT_EMPTY, '0, 1'b1);
               end else begin
                  fill_level--;
                  owe(lifo_pkg::STAT_POPPED, stack_words[fill_level], 1'b1);
               end
            end
            lifo_pkg::OP_DUMP: begin
               dumps++;
               if (fill_level == 0) begin
                  empties++;
                  owe(lifo_pkg::STAT_EMPTY, '0, 1'b1);
               end else begin
                  // walk top to bottom, last flag on the bottom entry
                  for (i = fill_level; i > 0; i--)
                     owe(lifo_pkg::STAT_DUMP, stack_words[i-1], i == 1);
               end
            end
            default: ;
         endcase
      endfunction

      function void check_response(rsp_word_type got);
         rsp_word_type want;
         if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: unexpected response status %0d data %08h last %0d",
                        $realtime, got.status, got.data, got.last);
            return;
         end
         want = owed_q.pop_front();
         words_checked++;
         if (got.status !== want.status || got.data !== want.data ||
             got.last !== want.last) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"%0t: response mismatch: expected status %0d data %08h last %0d,",
                         " got status %0d data %08h last %0d"},
                        $realtime, want.status, want.data, want.last,
                        got.status, got.data, got.last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   lifo_req_if req_ch ();
   lifo_rsp_if rsp_ch ();
   lifo_csr_if csr_ch ();

   bounded_lifo_stack dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   stack_scoreboard sb;
   bit          req_gaps_on;
   bit          rsp_stalls_on;
   bit          long_hold_request;
   int unsigned settings_used;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // End the run with an error once the time limit passes, in case traffic stops moving
   initial begin
      #5_000_000;
      $display("[bounded_lifo_stack] ERROR");
      $finish;
   end

   // Mostly no gap, some short ones, a few long ones
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic logic signed [lifo_pkg::WORD_W-1:0] pick_word();
      if ($urandom_range(9) != 0) return $urandom;
      case ($urandom_range(3))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   // Response side: one ready update per edge, random or long hold-off
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_ch.ready <= 1'b0;
            hold_left = LONG_HOLD - 1;
         end else if (rsp_stalls_on && (pick_gap() > 0)) begin
            rsp_ch.ready <= 1'b0;
            hold_left = pick_gap();
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Check every response word taken by the sink
   always @(posedge clock) begin
      rsp_word_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.status = lifo_pkg::status_type'(rsp_ch.status);
         got.data   = rsp_ch.data;
         got.last   = rsp_ch.last;
         sb.check_response(got);
      end
   end

   // Offer one request word and hold it until taken; valid stays high after
   task automatic send_request(logic [1:0] op, logic signed [lifo_pkg::WORD_W-1:0] value);
      int unsigned gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op    <= op;
      req_ch.value <= value;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_request(op, value);
   endtask

   // Drop valid, wait until every owed word has come back, then wait out the settle time
   task automatic wait_drained(int unsigned settle);
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.owed_q.size() > 0);
      repeat (settle) @(posedge clock);
   endtask

   // Capacity write; only called while the block is idle
   task automatic write_capacity(logic [lifo_pkg::CAP_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      sb.set_capacity(value);
      csr_ch.valid <= 1'b0;
      settings_used++;
   endtask

   // Random traffic in runs that lean toward filling or draining
   task automatic random_phase(int unsigned count, inout int unsigned total);
      int unsigned n, run_left, r;
      bit          filling;
      logic [1:0]  op;
      n = 0;
      run_left = 0;
      filling = 1'b1;
      while (n < count) begin
         if (run_left == 0) begin
            filling = ~filling;
            run_left = $urandom_range(20, 5);
         end
         run_left--;
         r = $urandom_range(99);
         if (r < 3)                             op = OP_UNUSED;
         else if (r < 9)                        op = lifo_pkg::OP_DUMP;
         else if (r < (filling ? 75 : 35))      op = lifo_pkg::OP_PUSH;
         else                                   op = lifo_pkg::OP_POP;
         // occasionally let everything drain before going on
         if ($urandom_range(49) == 0) wait_drained(0);
         send_request(op, pick_word());
         if (op != OP_UNUSED) begin
            n++;
            total++;
         end
      end
   endtask

   // Hold the response side off while pushes keep coming, then dump it all and pop once
   task automatic pressure_burst(inout int unsigned total);
      bit saved_gaps;
      saved_gaps = req_gaps_on;
      req_gaps_on = 1'b0;
      long_hold_request = 1'b1;
      repeat (lifo_pkg::DEPTH + 6) begin
         send_request(lifo_pkg::OP_PUSH, pick_word());
         total++;
      end
      send_request(lifo_pkg::OP_DUMP, '0);
      send_request(lifo_pkg::OP_POP, '0);
      total += 2;
      req_gaps_on = saved_gaps;
   endtask

   initial begin
      logic [lifo_pkg::CAP_W-1:0] caps [10];
      int unsigned random_done, phase;
      caps = '{7'd127, 7'd64, 7'd1, 7'd0, 7'd64, 7'd2, 7'd7, 7'd100, 7'd33, 7'd64};
      sb = new();
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      long_hold_request = 1'b0;
      settings_used = 0;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op    <= lifo_pkg::OP_PUSH;
      req_ch.value <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.data  <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty stack, unused op, field extremes at reset capacity
      send_request(lifo_pkg::OP_POP, 32'sh1234_5678);
      send_request(lifo_pkg::OP_DUMP, '0);
      send_request(OP_UNUSED, '1);
      send_request(lifo_pkg::OP_PUSH, 32'sh7FFF_FFFF);
      send_request(lifo_pkg::OP_PUSH, 32'sh8000_0000);
      send_request(lifo_pkg::OP_PUSH, '0);
      send_request(lifo_pkg::OP_PUSH, '1);
      send_request(lifo_pkg::OP_DUMP, '1);
      send_request(lifo_pkg::OP_POP, '0);
      send_request(OP_UNUSED, '0);
      send_request(lifo_pkg::OP_DUMP, '0);
      send_request(lifo_pkg::OP_POP, '0);
      send_request(lifo_pkg::OP_POP, '0);
      send_request(lifo_pkg::OP_POP, '0);
      send_request(lifo_pkg::OP_POP, '0);

      // capacity zero acts as one
      wait_drained(SETTLE_CYCLES);
      write_capacity(7'd0);
      send_request(lifo_pkg::OP_PUSH, 32'sh5A5A_5A5A);
      send_request(lifo_pkg::OP_PUSH, 32'sh0BAD_F00D);
      send_request(lifo_pkg::OP_DUMP, '0);

      // fill a small stack to the top
      wait_drained(SETTLE_CYCLES);
      write_capacity(7'd3);
      send_request(lifo_pkg::OP_PUSH, 32'sh0000_0001);
      send_request(lifo_pkg::OP_PUSH, 32'shFFFF_FFFE);
      send_request(lifo_pkg::OP_PUSH, 32'sh0000_0003);

      // lower capacity below the fill level: pushes refused, pops still work
      wait_drained(SETTLE_CYCLES);
      write_capacity(7'd1);
      send_request(lifo_pkg::OP_PUSH, 32'sh7777_7777);
      send_request(lifo_pkg::OP_DUMP, '0);
      send_request(lifo_pkg::OP_POP, '0);

      random_done = 0;
      phase = 0;
      while (random_done < RANDOM_ITEMS) begin
         wait_drained(SETTLE_CYCLES);
         if (phase < 10) write_capacity(caps[phase]);
         else write_capacity(lifo_pkg::CAP_W'($urandom_range(127)));
         req_gaps_on   = (phase % 4) != 1;
         rsp_stalls_on = (phase % 4) != 2;
         if (phase == 4) pressure_burst(random_done);
         random_phase(PHASE_ITEMS, random_done);
         phase++;
      end

      wait_drained(TAIL_CYCLES);
      $display("bounded_lifo_stack_tb: %0d pushes, %0d pops, %0d dumps; %0d words checked",
               sb.pushes, sb.pops, sb.dumps, sb.words_checked);
      $display("bounded_lifo_stack_tb: %0d capacity writes, deepest %0d, %0d full, %0d empty",
               settings_used, sb.deepest, sb.fulls, sb.empties);
      if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
         $display("[bounded_lifo_stack] OK");
      end else begin
         $display("bounded_lifo_stack_tb: %0d mismatches, %0d words still owed",
                  sb.mismatches, sb.owed_q.size());
         $display("[bounded_lifo_stack] ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
